// ===== hdl/slerp_pkg.sv =====
// Shared types and constants for the quaternion slerp pipeline.
package slerp_pkg;

    typedef struct packed {
        logic        [16:0] blend_ratio;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] start_z;
        logic signed [15:0] start_w;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic signed [15:0] end_z;
        logic signed [15:0] end_w;
    } t_slerp_in;

    typedef struct packed {
        logic signed [15:0] blend_x;
        logic signed [15:0] blend_y;
        logic signed [15:0] blend_z;
        logic signed [15:0] blend_w;
        logic               used_linear;
    } t_slerp_out;

    // Per-request sideband carried down the pipe.
    typedef struct packed {
        logic [16:0]      ratio;   // clamped t
        logic [3:0][15:0] qa;      // start quaternion, [0]=x .. [3]=w
        logic [3:0][15:0] qb;      // end quaternion
        logic             flip;    // dot was negative
        logic             lin;     // linear weights selected
    } t_side;

    localparam logic [16:0] RATIO_ONE    = 17'd65536;
    localparam logic [33:0] ONE_Q30      = 34'h0_4000_0000;
    localparam logic [63:0] GAIN_INV_Q32 = 64'd2608131496;
    localparam logic [15:0] THR_RESET    = 16'd66;

    // atan(2^-i) in binary angle, 2^32 per turn
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

endpackage

// ===== hdl/quaternion_slerp_core.sv =====
// Quaternion slerp core: fully pipelined, one request per cycle.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------
//  in       | sink      | i_in_valid / o_in_stall  | i_in_req  (t_slerp_in)
//  out      | source    | o_out_valid / i_out_stall| o_out_req (t_slerp_out)
//  cfg      | sink      | i_cfg_we                 | i_cfg_wdata (threshold)
//
// Throughput is one request per cycle unless the output stalls. The path runs through
// the bit-per-stage square root, the vectoring and rotation CORDICs and the
// bit-per-stage divider.
// Synchronous active-low reset clears all valid bits and loads the threshold (66).
// A stall on the output freezes every stage at once; nothing is dropped or repeated.
module quaternion_slerp_core #(
    parameter int FRAC_BITS    = 15,
    parameter int CORDIC_STEPS = 18
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [15:0]           i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  slerp_pkg::t_slerp_in  i_in_req,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output slerp_pkg::t_slerp_out o_out_req
);
    import slerp_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int N  = CORDIC_STEPS;
    localparam int RW = 2*F + 2;       // square root working width
    localparam int SW = F + 1;         // sin(omega) width
    localparam int XW = F + 3;         // CORDIC x/y width
    localparam int ZW = 33;            // CORDIC angle width
    localparam int QW = F + 2;         // kept quotient bits
    localparam int WW = F + 3;         // signed weight width
    localparam int DS = 2*F + 2;       // divider stages
    localparam int PW = WW + 16;       // weight product width
    localparam int AW = PW + 1;        // blend sum width
    localparam logic [63:0] GAIN_F = (GAIN_INV_Q32 + (64'd1 << (31 - F))) >> (32 - F);
    localparam logic [QW-1:0] W_LIM = QW'(1) << (F + 1);
    localparam logic signed [AW-1:0] SAT_HI = AW'(32767);
    localparam logic signed [AW-1:0] SAT_LO = AW'(-32768);
    localparam logic signed [AW-1:0] RND    = AW'(1) << (F - 1);

    // Global advance: whole pipe moves unless the output holds a stalled result.
    logic w_adv;
    logic r_out_valid;
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_adv;

    // Threshold register
    logic [15:0] r_thr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // ---------------- Stage A: clamp t, four partial products ----------------
    t_side              w_in_side;
    logic               r_a_vld;
    t_side              r_a_side;
    logic signed [31:0] r_a_prod [4];

    always_comb begin
        w_in_side.ratio = (i_in_req.blend_ratio > RATIO_ONE) ? RATIO_ONE
                                                             : i_in_req.blend_ratio;
        w_in_side.qa    = {i_in_req.start_w, i_in_req.start_z,
                           i_in_req.start_y, i_in_req.start_x};
        w_in_side.qb    = {i_in_req.end_w, i_in_req.end_z,
                           i_in_req.end_y, i_in_req.end_x};
        w_in_side.flip  = 1'b0;
        w_in_side.lin   = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_side <= w_in_side;
            for (int k = 0; k < 4; k++) begin
                r_a_prod[k] <= $signed(w_in_side.qa[k]) * $signed(w_in_side.qb[k]);
            end
        end
    end

    // ---------------- Stage B: dot sum, short arc, threshold test ------------
    logic signed [33:0] w_dot;
    logic        [33:0] w_mag;
    logic        [30:0] w_c;
    logic        [30:0] w_gap;
    t_side              w_b_side;
    logic               r_b_vld;
    t_side              r_b_side;
    logic [F:0]         r_b_cf;
    logic               r_b_arc;

    always_comb begin
        w_dot = 34'(r_a_prod[0]) + 34'(r_a_prod[1]) + 34'(r_a_prod[2]) + 34'(r_a_prod[3]);
        w_mag = w_dot[33] ? 34'(-w_dot) : 34'(w_dot);
        w_c   = (w_mag > ONE_Q30) ? ONE_Q30[30:0] : w_mag[30:0];
        w_gap = ONE_Q30[30:0] - w_c;
        w_b_side      = r_a_side;
        w_b_side.flip = w_dot[33];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_adv) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_side      <= w_b_side;
            r_b_cf        <= w_c[30:30-F];
            r_b_arc       <= w_gap > {1'b0, r_thr, 14'd0};
        end
    end

    // ---------------- Stage C + square root of 1 - cos^2 --------------------
    logic [RW-1:0] w_sq;
    logic          r_sq_vld  [F+2];
    logic [RW-1:0] r_sq_v    [F+2];
    logic [RW-1:0] r_sq_r    [F+2];
    logic [F:0]    r_sq_cf   [F+2];
    logic          r_sq_arc  [F+2];
    t_side         r_sq_side [F+2];

    assign w_sq = RW'(r_b_cf) * RW'(r_b_cf);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_sq_vld[0] <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq_v[0]    <= (RW'(1) << (2*F)) - w_sq;
            r_sq_r[0]    <= '0;
            r_sq_cf[0]   <= r_b_cf;
            r_sq_arc[0]  <= r_b_arc;
            r_sq_side[0] <= r_b_side;
        end
    end

    for (genvar j = 0; j <= F; j++) begin : g_sqrt
        localparam logic [RW-1:0] BIT = RW'(1) << (2*(F - j));
        logic [RW-1:0] w_trial;
        logic          w_ge;
        assign w_trial = r_sq_r[j] + BIT;
        assign w_ge    = r_sq_v[j] >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[j+1] <= 1'b0;
            end else if (w_adv) begin
                r_sq_vld[j+1] <= r_sq_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sq_v[j+1]    <= w_ge ? (r_sq_v[j] - w_trial) : r_sq_v[j];
                r_sq_r[j+1]    <= w_ge ? ((r_sq_r[j] >> 1) + BIT) : (r_sq_r[j] >> 1);
                r_sq_cf[j+1]   <= r_sq_cf[j];
                r_sq_arc[j+1]  <= r_sq_arc[j];
                r_sq_side[j+1] <= r_sq_side[j];
            end
        end
    end

    // ---------------- Vectoring CORDIC: omega = atan2(sin, cos) --------------
    logic [SW-1:0]        w_s;
    t_side                w_vc_side;
    logic                 r_vc_vld  [N+1];
    logic signed [XW-1:0] r_vc_x    [N+1];
    logic signed [XW-1:0] r_vc_y    [N+1];
    logic signed [ZW-1:0] r_vc_z    [N+1];
    logic [SW-1:0]        r_vc_s    [N+1];
    t_side                r_vc_side [N+1];

    assign w_s = r_sq_r[F+1][SW-1:0];

    always_comb begin
        w_vc_side     = r_sq_side[F+1];
        w_vc_side.lin = !(r_sq_arc[F+1] && (w_s != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_vc_vld[0] <= r_sq_vld[F+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_vc_x[0]        <= $signed({2'b00, r_sq_cf[F+1]});
            r_vc_y[0]        <= $signed({2'b00, w_s});
            r_vc_z[0]        <= '0;
            r_vc_s[0]        <= w_s;
            r_vc_side[0]     <= w_vc_side;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_vec
        localparam logic signed [ZW-1:0] AT = ZW'(ATAN_TAB[i]);
        logic signed [XW-1:0] w_dx;
        logic signed [XW-1:0] w_dy;
        assign w_dx = r_vc_y[i] >>> i;
        assign w_dy = r_vc_x[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vc_vld[i+1] <= 1'b0;
            end else if (w_adv) begin
                r_vc_vld[i+1] <= r_vc_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (!r_vc_y[i][XW-1]) begin
                    r_vc_x[i+1] <= r_vc_x[i] + w_dx;
                    r_vc_y[i+1] <= r_vc_y[i] - w_dy;
                    r_vc_z[i+1] <= r_vc_z[i] + AT;
                end else begin
                    r_vc_x[i+1] <= r_vc_x[i] - w_dx;
                    r_vc_y[i+1] <= r_vc_y[i] + w_dy;
                    r_vc_z[i+1] <= r_vc_z[i] - AT;
                end
                r_vc_s[i+1]    <= r_vc_s[i];
                r_vc_side[i+1] <= r_vc_side[i];
            end
        end
    end

    // ---------------- Angle split, then rotation CORDICs (two lanes) ---------
    logic [30:0]          w_om;
    logic [47:0]          w_pa;
    logic [47:0]          w_pb;
    logic                 r_rt_vld  [N+1];
    logic signed [XW-1:0] r_rt_x    [2][N+1];
    logic signed [XW-1:0] r_rt_y    [2][N+1];
    logic signed [ZW-1:0] r_rt_z    [2][N+1];
    logic [SW-1:0]        r_rt_s    [N+1];
    t_side                r_rt_side [N+1];

    always_comb begin
        if (r_vc_z[N][ZW-1]) begin
            w_om = '0;
        end else if (r_vc_z[N] > $signed(ZW'(ONE_Q30))) begin
            w_om = ONE_Q30[30:0];
        end else begin
            w_om = r_vc_z[N][30:0];
        end
        w_pa = 48'(RATIO_ONE - r_vc_side[N].ratio) * 48'(w_om);
        w_pb = 48'(r_vc_side[N].ratio) * 48'(w_om);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_rt_vld[0] <= r_vc_vld[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rt_x[0][0] <= $signed(GAIN_F[XW-1:0]);
            r_rt_x[1][0] <= $signed(GAIN_F[XW-1:0]);
            r_rt_y[0][0] <= '0;
            r_rt_y[1][0] <= '0;
            r_rt_z[0][0] <= $signed({2'b00, w_pa[46:16]});
            r_rt_z[1][0] <= $signed({2'b00, w_pb[46:16]});
            r_rt_s[0]    <= r_vc_s[N];
            r_rt_side[0] <= r_vc_side[N];
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
        localparam logic signed [ZW-1:0] AT = ZW'(ATAN_TAB[i]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_vld[i+1] <= 1'b0;
            end else if (w_adv) begin
                r_rt_vld[i+1] <= r_rt_vld[i];
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic signed [XW-1:0] w_dx;
            logic signed [XW-1:0] w_dy;
            assign w_dx = r_rt_y[l][i] >>> i;
            assign w_dy = r_rt_x[l][i] >>> i;

            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    if (!r_rt_z[l][i][ZW-1]) begin
                        r_rt_x[l][i+1] <= r_rt_x[l][i] - w_dx;
                        r_rt_y[l][i+1] <= r_rt_y[l][i] + w_dy;
                        r_rt_z[l][i+1] <= r_rt_z[l][i] - AT;
                    end else begin
                        r_rt_x[l][i+1] <= r_rt_x[l][i] + w_dx;
                        r_rt_y[l][i+1] <= r_rt_y[l][i] - w_dy;
                        r_rt_z[l][i+1] <= r_rt_z[l][i] + AT;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rt_s[i+1]    <= r_rt_s[i];
                r_rt_side[i+1] <= r_rt_side[i];
            end
        end
    end

    // ---------------- Restoring divider: sine * 2^F / sin(omega) ------------
    logic          r_dv_vld  [DS+1];
    logic [F:0]    r_dv_rem  [2][DS+1];
    logic [QW-1:0] r_dv_q    [2][DS+1];
    logic          r_dv_big  [2][DS+1];
    logic [F+1:0]  r_dv_sn   [2][DS+1];
    logic [SW-1:0] r_dv_s    [DS+1];
    t_side         r_dv_side [DS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_dv_vld[0] <= r_rt_vld[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv_rem[0][0] <= '0;
            r_dv_rem[1][0] <= '0;
            r_dv_q[0][0]   <= '0;
            r_dv_q[1][0]   <= '0;
            r_dv_big[0][0] <= 1'b0;
            r_dv_big[1][0] <= 1'b0;
            r_dv_sn[0][0]  <= r_rt_y[0][N][XW-1] ? '0 : r_rt_y[0][N][F+1:0];
            r_dv_sn[1][0]  <= r_rt_y[1][N][XW-1] ? '0 : r_rt_y[1][N][F+1:0];
            r_dv_s[0]    <= r_rt_s[N];
            r_dv_side[0] <= r_rt_side[N];
        end
    end

    for (genvar j = 0; j < DS; j++) begin : g_div
        localparam int P = DS - 1 - j;    // dividend bit position

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else if (w_adv) begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic          w_nb;
            logic [F+1:0]  w_trial;
            logic [F+1:0]  w_diff;
            logic          w_ge;
            if (P >= F) begin : g_bit
                assign w_nb = r_dv_sn[l][j][P-F];
            end else begin : g_zero
                assign w_nb = 1'b0;
            end
            assign w_trial = {r_dv_rem[l][j], w_nb};
            assign w_ge    = w_trial >= {1'b0, r_dv_s[j]};
            assign w_diff  = w_trial - {1'b0, r_dv_s[j]};

            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_dv_rem[l][j+1] <= w_ge ? w_diff[F:0] : w_trial[F:0];
                    r_dv_q[l][j+1]   <= {r_dv_q[l][j][QW-2:0], w_ge};
                    r_dv_big[l][j+1] <= r_dv_big[l][j] | r_dv_q[l][j][QW-1];
                    r_dv_sn[l][j+1]  <= r_dv_sn[l][j];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_s[j+1]    <= r_dv_s[j];
                r_dv_side[j+1] <= r_dv_side[j];
            end
        end
    end

    // ---------------- Stage W: weight select, clamp, short-arc flip ----------
    logic [16+F:0]        w_lin_a_wide;
    logic [16+F:0]        w_lin_b_wide;
    logic [QW-1:0]        w_qa;
    logic [QW-1:0]        w_qb;
    logic [QW-1:0]        w_ua;
    logic [QW-1:0]        w_ub;
    logic signed [WW-1:0] w_sb;
    logic                 r_w_vld;
    logic signed [WW-1:0] r_w_wa;
    logic signed [WW-1:0] r_w_wb;
    t_side                r_w_side;

    always_comb begin
        w_lin_a_wide = {17'(RATIO_ONE - r_dv_side[DS].ratio), {F{1'b0}}};
        w_lin_b_wide = {r_dv_side[DS].ratio, {F{1'b0}}};
        w_qa = (r_dv_big[0][DS] || r_dv_q[0][DS] > W_LIM) ? W_LIM : r_dv_q[0][DS];
        w_qb = (r_dv_big[1][DS] || r_dv_q[1][DS] > W_LIM) ? W_LIM : r_dv_q[1][DS];
        if (r_dv_side[DS].lin) begin
            w_ua = {1'b0, w_lin_a_wide[16+F:16]};
            w_ub = {1'b0, w_lin_b_wide[16+F:16]};
        end else begin
            w_ua = w_qa;
            w_ub = w_qb;
        end
        w_sb = $signed({1'b0, w_ub});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_vld <= 1'b0;
        end else if (w_adv) begin
            r_w_vld <= r_dv_vld[DS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_w_wa   <= $signed({1'b0, w_ua});
            r_w_wb   <= r_dv_side[DS].flip ? -w_sb : w_sb;
            r_w_side <= r_dv_side[DS];
        end
    end

    // ---------------- Stage P: weighted products ------------------------------
    logic                 r_p_vld;
    logic                 r_p_lin;
    logic signed [PW-1:0] r_p_pa [4];
    logic signed [PW-1:0] r_p_pb [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (w_adv) begin
            r_p_vld <= r_w_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_lin <= r_w_side.lin;
            for (int k = 0; k < 4; k++) begin
                r_p_pa[k] <= r_w_wa * $signed(r_w_side.qa[k]);
                r_p_pb[k] <= r_w_wb * $signed(r_w_side.qb[k]);
            end
        end
    end

    // ---------------- Output register: sum, round, saturate -------------------
    logic signed [AW-1:0] w_sum [4];
    logic signed [AW-1:0] w_sh  [4];
    logic signed [15:0]   w_res [4];
    t_slerp_out           r_out_req;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_sum[k] = AW'(r_p_pa[k]) + AW'(r_p_pb[k]) + RND;
            w_sh[k]  = w_sum[k] >>> F;
            if (w_sh[k] > SAT_HI) begin
                w_res[k] = 16'sh7FFF;
            end else if (w_sh[k] < SAT_LO) begin
                w_res[k] = -16'sh8000;
            end else begin
                w_res[k] = w_sh[k][15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_req.blend_x     <= w_res[0];
            r_out_req.blend_y     <= w_res[1];
            r_out_req.blend_z     <= w_res[2];
            r_out_req.blend_w     <= w_res[3];
            r_out_req.used_linear <= r_p_lin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

`ifndef NO_ASSERTIONS
    // reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // square root never exceeds one in Q.F
    a_sqrt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_vld[F+1] |-> (r_sq_r[F+1] <= (RW'(1) << F)))
        else $error("sin(omega) above one");

    // divider remainder ends below divisor on the arc path
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_vld[DS] && !r_dv_side[DS].lin) |->
            ((r_dv_rem[0][DS] < r_dv_s[DS]) && (r_dv_rem[1][DS] < r_dv_s[DS])))
        else $error("divider remainder out of range");

    // a held result blocks new requests
    a_hold_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(r_p_vld))
        else $error("pipe moved under stall");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the quaternion slerp core: directed table, then random requests.
module tb_top;
    import slerp_pkg::*;

    localparam int FB    = 15;
    localparam int STEPS = 18;
    localparam int LAT   = 3 * FB + 2 * STEPS + 12;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_slerp_in  i_in_req = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_slerp_out o_out_req;

    quaternion_slerp_core #(.FRAC_BITS(FB), .CORDIC_STEPS(STEPS)) DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bench-side copy of the epsilon register.
    logic [15:0] eps_q16;
    t_slerp_out  blend_due[$];
    int          fail_cnt = 0;
    int          n_sent = 0, n_got = 0, n_linear = 0;
    int          send_idle_pct = 0, recv_idle_pct = 0;

    // Arithmetic shift right, rounding toward minus infinity (>>> on signed longint).
    function automatic longint sra(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    // Vectoring CORDIC: angle of (x, y) as binary angle, clamped to a quarter turn.
    function automatic longint arc_angle(longint x, longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = sra(y, i);
            dy = sra(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end
        end
        if (z < 0) z = 0;
        if (z > (64'sd1 <<< 30)) z = 64'sd1 <<< 30;
        return z;
    endfunction

    // Rotation CORDIC starting from the inverse gain; returns sine, floored at zero.
    function automatic longint arc_sine(longint z);
        longint x, y, dx, dy;
        x = (longint'(GAIN_INV_Q32) + (64'sd1 <<< (31 - FB))) >>> (32 - FB);
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = sra(y, i);
            dy = sra(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end
        end
        return (y < 0) ? 0 : y;
    endfunction

    function automatic longint ratio_weight(longint sn, longint s);
        longint q;
        q = (sn <<< FB) / s;
        return (q > (64'sd2 <<< FB)) ? (64'sd2 <<< FB) : q;
    endfunction

    function automatic t_slerp_out slerp_predict(t_slerp_in rq);
        longint     a[4], b[4], dot, c, wa, wb, t, cf, s, om, sum, r;
        logic       flip;
        t_slerp_out res;
        t = rq.blend_ratio;
        if (t > 65536) t = 65536;
        a = '{rq.start_x, rq.start_y, rq.start_z, rq.start_w};
        b = '{rq.end_x, rq.end_y, rq.end_z, rq.end_w};
        dot = 0;
        for (int k = 0; k < 4; k++) dot += a[k] * b[k];
        flip = dot < 0;
        c = flip ? -dot : dot;
        if (c > (64'sd1 <<< 30)) c = 64'sd1 <<< 30;
        wa = ((65536 - t) <<< FB) >>> 16;
        wb = (t <<< FB) >>> 16;
        res.used_linear = 1'b1;
        if ((64'sd1 <<< 30) - c > (longint'(eps_q16) <<< 14)) begin
            cf = c >>> (30 - FB);
            s = int_sqrt((64'sd1 <<< (2 * FB)) - cf * cf);
            if (s != 0) begin
                om = arc_angle(cf, s);
                wa = ratio_weight(arc_sine(((65536 - t) * om) >>> 16), s);
                wb = ratio_weight(arc_sine((t * om) >>> 16), s);
                res.used_linear = 1'b0;
            end
        end
        if (flip) wb = -wb;
        for (int k = 0; k < 4; k++) begin
            sum = wa * a[k] + wb * b[k];
            r = sra(sum + (64'sd1 <<< (FB - 1)), FB);
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            case (k)
                0: res.blend_x = r[15:0];
                1: res.blend_y = r[15:0];
                2: res.blend_z = r[15:0];
                default: res.blend_w = r[15:0];
            endcase
        end
        return res;
    endfunction

    // Output side: random stall, compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_slerp_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_got++;
            if (blend_due.size() == 0) begin
                $error("unexpected result %p", o_out_req);
                fail_cnt++;
            end else begin
                want = blend_due.pop_front();
                if (o_out_req.blend_x !== want.blend_x) begin
                    $error("blend_x exp %0d got %0d", want.blend_x, o_out_req.blend_x);
                    fail_cnt++;
                end
                if (o_out_req.blend_y !== want.blend_y) begin
                    $error("blend_y exp %0d got %0d", want.blend_y, o_out_req.blend_y);
                    fail_cnt++;
                end
                if (o_out_req.blend_z !== want.blend_z) begin
                    $error("blend_z exp %0d got %0d", want.blend_z, o_out_req.blend_z);
                    fail_cnt++;
                end
                if (o_out_req.blend_w !== want.blend_w) begin
                    $error("blend_w exp %0d got %0d", want.blend_w, o_out_req.blend_w);
                    fail_cnt++;
                end
                if (o_out_req.used_linear !== want.used_linear) begin
                    $error("used_linear exp %0b got %0b", want.used_linear,
                           o_out_req.used_linear);
                    fail_cnt++;
                end
                if (want.used_linear) n_linear++;
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Present one request, honoring the sender idle rate, and wait for acceptance.
    // Valid stays up after acceptance; the next call or the caller drops it.
    task automatic send_req(t_slerp_in rq, logic chk, t_slerp_out fixed);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_req   <= rq;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        blend_due.push_back(chk ? fixed : slerp_predict(rq));
        n_sent++;
    endtask

    task automatic drain_then_set(logic [15:0] eps);
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (blend_due.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LAT + 4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= eps;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        eps_q16      = eps;
    endtask

    // Random unit-ish quaternion; some pairs are near each other, some opposite.
    function automatic t_slerp_in rand_req(int mode);
        t_slerp_in rq;
        logic [15:0] v[8];
        int shape;
        for (int k = 0; k < 8; k++) v[k] = 16'($urandom);
        shape = $urandom_range(3);
        if (mode == 0) begin
            // scaled down so the dot stays at or under one
            for (int k = 0; k < 8; k++) v[k] = 16'($signed(v[k]) >>> 1);
            if (shape == 0) for (int k = 0; k < 4; k++)
                v[4 + k] = v[k] + 16'($urandom_range(8) - 4);
            if (shape == 1) for (int k = 0; k < 4; k++)
                v[4 + k] = -v[k] + 16'($urandom_range(8) - 4);
        end
        rq.blend_ratio = ($urandom_range(15) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
        {rq.start_x, rq.start_y, rq.start_z, rq.start_w} = {v[0], v[1], v[2], v[3]};
        {rq.end_x, rq.end_y, rq.end_z, rq.end_w}         = {v[4], v[5], v[6], v[7]};
        return rq;
    endfunction

    typedef struct {
        t_slerp_in  rq;
        logic       chk;
        t_slerp_out fixed;
    } t_case;

    initial begin
        t_case cases[$];
        t_slerp_in q0;
        logic [15:0] eps_list[5];
        eps_q16 = THR_RESET;
        eps_list = '{16'd0, 16'hFFFF, 16'd1, 16'd3000, THR_RESET};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows. Identical unit quaternions: linear, output equals input.
        q0 = '{17'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd32767};
        cases.push_back('{q0, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 1'b1}});
        q0.blend_ratio = RATIO_ONE;
        cases.push_back('{q0, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 1'b1}});
        // ratio above one saturates
        q0.blend_ratio = 17'h1FFFF;
        cases.push_back('{q0, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 1'b1}});
        // all-zero inputs: zero dot, zero out
        cases.push_back('{'{17'd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                            16'sd0}, 1'b0, '0});
        // orthogonal: spherical path
        cases.push_back('{'{17'd32768, 16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767,
                            16'sd0, 16'sd0}, 1'b0, '0});
        cases.push_back('{'{17'd16384, 16'sd0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                            16'sd32767}, 1'b0, '0});
        // negative dot, shorter arc flips B
        cases.push_back('{'{17'd32768, 16'sd23170, 16'sd0, 16'sd0, 16'sd23170, 16'sd0, 16'sd0,
                            -16'sd23170, -16'sd23170}, 1'b0, '0});
        // opposite quaternions
        cases.push_back('{'{17'd40000, 16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0, -16'sd32768,
                            16'sd0, 16'sd0}, 1'b0, '0});
        // non-unit extremes: the dot magnitude clamps to one in the first two rows
        cases.push_back('{'{17'd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                            -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, '0});
        cases.push_back('{'{17'd1, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768,
                            -16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, '0});
        cases.push_back('{'{17'd65535, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
                            16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768}, 1'b0, '0});
        // near-parallel pair straddling the default epsilon
        cases.push_back('{'{17'd30000, 16'sd0, 16'sd0, 16'sd1000, 16'sd32752, 16'sd0, 16'sd0,
                            16'sd1100, 16'sd32749}, 1'b0, '0});
        cases.push_back('{'{17'd30000, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0,
                            16'sd2600, 16'sd32664}, 1'b0, '0});

        foreach (cases[i]) send_req(cases[i].rq, cases[i].chk, cases[i].fixed);

        // Random part in five phases with three idling mixes, epsilon set before each phase.
        for (int ph = 0; ph < 5; ph++) begin
            drain_then_set(eps_list[ph]);
            send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 65 : 0;
            recv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 31 : 0;
            repeat (90) send_req(rand_req($urandom_range(4) == 0), 1'b0, '0);
        end

        i_in_valid <= 1'b0;
        while (blend_due.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
        $display("%0d requests sent, %0d results checked (%0d linear), 5 epsilon settings",
                 n_sent, n_got, n_linear);
        $display("idle mixes: sender-heavy, receiver-heavy, none; extremes of ratio and q");
        if (fail_cnt == 0 && blend_due.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule
